### hdl/ftd_pkg.sv
// Package for the fixed-point to decimal text converter.
// Holds the widths, character codes, shared-unit operation codes and result type.
// Depends on nothing; every other file of the block uses it.
package ftd_pkg;

    localparam int INT_BITS        = 31;
    localparam int FRAC_BITS       = 32;
    localparam int FRACTION_DIGITS = 4;
    localparam int MAX_CHARS       = 16;
    localparam int INT_DIGITS      = 10;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int BCD_W           = INT_DIGITS * DIGIT_W;
    localparam int FDIG_W          = FRACTION_DIGITS * DIGIT_W;
    localparam int PROD_W          = FRAC_BITS + DIGIT_W;
    localparam int CNT_W           = $clog2(INT_BITS);
    localparam int IDX_W           = $clog2(INT_DIGITS);
    localparam int NDIG_W          = $clog2(INT_DIGITS + 1);
    localparam int FCNT_W          = $clog2(FRACTION_DIGITS + 1);
    localparam int LEN_W           = $clog2(MAX_CHARS + 1);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

    typedef enum logic [1:0] {
        ALU_DABBLE  = 2'b01,
        ALU_TIMES10 = 2'b10
    } t_alu_op;

    typedef struct packed {
        logic [BCD_W-1:0]     bcd;
        logic [INT_BITS-1:0]  bin;
        logic [FRAC_BITS-1:0] frac;
        logic [DIGIT_W-1:0]   digit;
    } t_alu_res;

endpackage

### hdl/ftd_if.sv
// Channel interfaces of the fixed-point to decimal text converter.
// One interface for the number channel and one for the character channel.
// Depends on ftd_pkg.
interface ftd_in_if;
    logic                            valid;
    logic                            ready;
    logic                            negative;
    logic [ftd_pkg::INT_BITS-1:0]    integer_part;
    logic [ftd_pkg::FRAC_BITS-1:0]   fraction;

    modport source (output valid, negative, integer_part, fraction, input ready);
    modport sink   (input valid, negative, integer_part, fraction, output ready);
endinterface

interface ftd_out_if;
    logic                          valid;
    logic                          ready;
    logic [ftd_pkg::CHAR_W-1:0]    char_code;
    logic                          last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

### hdl/ftd_alu.sv
// Shared arithmetic unit of the converter: one double-dabble step or one
// multiplication of the fraction by ten, chosen by the sequencer.
// Depends on ftd_pkg.
module ftd_alu (
    input  ftd_pkg::t_alu_op              i_op,
    input  logic [ftd_pkg::BCD_W-1:0]     i_bcd,
    input  logic [ftd_pkg::INT_BITS-1:0]  i_bin,
    input  logic [ftd_pkg::FRAC_BITS-1:0] i_frac,
    output ftd_pkg::t_alu_res             o_res
);
    import ftd_pkg::*;

    logic [BCD_W-1:0]  w_adj;
    logic [PROD_W-1:0] w_prod;

    always_comb begin
        w_adj = i_bcd;
        for (int k = 0; k < INT_DIGITS; k++) begin
            if (i_bcd[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                w_adj[k*DIGIT_W +: DIGIT_W] = i_bcd[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
        end
    end

    // Ten times the fraction as eight times plus two times.
    assign w_prod = {1'b0, i_frac, 3'b000} + {3'b000, i_frac, 1'b0};

    always_comb begin
        o_res.bcd   = i_bcd;
        o_res.bin   = i_bin;
        o_res.frac  = i_frac;
        o_res.digit = '0;
        unique case (i_op)
            ALU_DABBLE: begin
                o_res.bcd = {w_adj[BCD_W-2:0], i_bin[INT_BITS-1]};
                o_res.bin = {i_bin[INT_BITS-2:0], 1'b0};
            end
            ALU_TIMES10: begin
                o_res.frac  = w_prod[FRAC_BITS-1:0];
                o_res.digit = w_prod[PROD_W-1:FRAC_BITS];
            end
            default: begin
                o_res.digit = '0;
            end
        endcase
    end

endmodule

### hdl/fixed_to_decimal_text_core.sv
// Top level of the fixed-point to decimal text converter: sequencer,
// working registers and character output register.
// Depends on ftd_pkg, ftd_if and ftd_alu.
//
//  Channel  Direction  Word                                    Handshake
//  i_num    in         negative, integer_part, fraction        valid/ready
//  o_text   out        char_code, last (one character a word)  valid/ready
//
// A number is taken only while the block is idle. It then runs double-dabble
// through the shared unit (one integer bit a cycle), then makes one fraction digit
// a cycle, trims, and sends one character a cycle while the output register is free.
// Reset clears the sequencer and the output valid; no word is lost on stalls,
// as a character is only loaded when the output register is free.
module fixed_to_decimal_text_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ftd_in_if.sink     i_num,
    ftd_out_if.source  o_text
);
    import ftd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_FRAC = 5'b00100,
        ST_TRIM = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [INT_BITS-1:0]   r_bin, n_bin;
    logic [FRAC_BITS-1:0]  r_frac, n_frac;
    logic [FDIG_W-1:0]     r_fdig, n_fdig;
    logic [NDIG_W-1:0]     r_icnt, n_icnt;
    logic [FCNT_W-1:0]     r_fcnt, n_fcnt;
    logic                  r_sign_pend, n_sign_pend;
    logic                  r_point_pend, n_point_pend;
    logic                  r_o_valid, n_o_valid;
    logic [CHAR_W-1:0]     r_o_char, n_o_char;
    logic                  r_o_last, n_o_last;

    t_alu_op               w_op;
    t_alu_res              w_res;
    logic [DIGIT_W-1:0]    w_int_dig [INT_DIGITS];
    logic [IDX_W-1:0]      w_int_idx;
    logic [NDIG_W-1:0]     w_ndig;
    logic [LEN_W-1:0]      w_keep;
    logic [LEN_W-1:0]      w_avail;
    logic [LEN_W-1:0]      w_lim;
    logic [FCNT_W-1:0]     w_nfrac;
    logic                  w_out_free;

    assign w_op = (r_state == ST_FRAC) ? ALU_TIMES10 : ALU_DABBLE;

    ftd_alu u_alu (
        .i_op   (w_op),
        .i_bcd  (r_bcd),
        .i_bin  (r_bin),
        .i_frac (r_frac),
        .o_res  (w_res)
    );

    always_comb begin
        for (int k = 0; k < INT_DIGITS; k++) begin
            w_int_dig[k] = r_bcd[k*DIGIT_W +: DIGIT_W];
        end
    end

    // Number of integer digits, at least one.
    always_comb begin
        w_ndig = NDIG_W'(1);
        for (int k = 1; k < INT_DIGITS; k++) begin
            if (w_int_dig[k] != '0) begin
                w_ndig = NDIG_W'(k + 1);
            end
        end
    end

    // Fraction digits that fit within the character limit, then trailing zeros dropped.
    assign w_keep  = LEN_W'(r_neg) + LEN_W'(w_ndig) + LEN_W'(1);
    assign w_avail = LEN_W'(MAX_CHARS) - w_keep;
    assign w_lim   = (w_avail < LEN_W'(FRACTION_DIGITS)) ? w_avail : LEN_W'(FRACTION_DIGITS);

    always_comb begin
        w_nfrac = '0;
        for (int k = 0; k < FRACTION_DIGITS; k++) begin
            if ((LEN_W'(k) < w_lim) && (r_fdig[FDIG_W-1-k*DIGIT_W -: DIGIT_W] != '0)) begin
                w_nfrac = FCNT_W'(k + 1);
            end
        end
    end

    assign w_int_idx  = IDX_W'(r_icnt - NDIG_W'(1));
    assign w_out_free = !r_o_valid || o_text.ready;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_bcd        = r_bcd;
        n_bin        = r_bin;
        n_frac       = r_frac;
        n_fdig       = r_fdig;
        n_icnt       = r_icnt;
        n_fcnt       = r_fcnt;
        n_sign_pend  = r_sign_pend;
        n_point_pend = r_point_pend;
        n_o_valid    = r_o_valid && !o_text.ready;
        n_o_char     = r_o_char;
        n_o_last     = r_o_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_num.valid) begin
                    n_neg   = i_num.negative;
                    n_bin   = i_num.integer_part;
                    n_frac  = i_num.fraction;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = w_res.bcd;
                n_bin = w_res.bin;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(INT_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_FRAC;
                end
            end
            ST_FRAC: begin
                n_frac = w_res.frac;
                n_fdig = FDIG_W'({r_fdig, w_res.digit});
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRACTION_DIGITS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                n_icnt       = w_ndig;
                n_fcnt       = w_nfrac;
                n_sign_pend  = r_neg;
                n_point_pend = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    if (r_sign_pend) begin
                        n_o_char    = CH_MINUS;
                        n_o_last    = 1'b0;
                        n_sign_pend = 1'b0;
                    end else if (r_icnt != '0) begin
                        n_o_char = CH_ZERO + CHAR_W'(w_int_dig[w_int_idx]);
                        n_o_last = 1'b0;
                        n_icnt   = r_icnt - NDIG_W'(1);
                    end else if (r_point_pend) begin
                        n_o_char     = CH_POINT;
                        n_o_last     = (r_fcnt == '0);
                        n_point_pend = 1'b0;
                        if (r_fcnt == '0) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_o_char = CH_ZERO + CHAR_W'(r_fdig[FDIG_W-1 -: DIGIT_W]);
                        n_o_last = (r_fcnt == FCNT_W'(1));
                        n_fcnt   = r_fcnt - FCNT_W'(1);
                        n_fdig   = FDIG_W'({r_fdig, DIGIT_W'(0)});
                        if (r_fcnt == FCNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_icnt       <= '0;
            r_fcnt       <= '0;
            r_sign_pend  <= 1'b0;
            r_point_pend <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_icnt       <= n_icnt;
            r_fcnt       <= n_fcnt;
            r_sign_pend  <= n_sign_pend;
            r_point_pend <= n_point_pend;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_bcd    <= n_bcd;
        r_bin    <= n_bin;
        r_frac   <= n_frac;
        r_fdig   <= n_fdig;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign i_num.ready      = (r_state == ST_IDLE);
    assign o_text.valid     = r_o_valid;
    assign o_text.char_code = r_o_char;
    assign o_text.last      = r_o_last;

endmodule

### hdl/ftd_checker.sv
// Port-level checks of the fixed-point to decimal text converter, and the
// bind statement that attaches them to the top level.
// Depends on ftd_pkg and fixed_to_decimal_text_core.
module ftd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ftd_pkg::CHAR_W-1:0]    i_out_char,
    input logic                          i_out_last
);
    import ftd_pkg::*;

    // The block works on one number at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready straight after a number was taken");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_char >= CH_ZERO && i_out_char <= CH_NINE)
                         || i_out_char == CH_MINUS || i_out_char == CH_POINT))
        else $error("character outside digits, minus and point");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_char == CH_MINUS) |-> !i_out_last)
        else $error("minus sign marked as the final character");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_char)))
        else $error("stalled character word dropped or changed");

endmodule

bind fixed_to_decimal_text_core ftd_checker u_ftd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_num.valid),
    .i_in_ready  (i_num.ready),
    .i_out_valid (o_text.valid),
    .i_out_ready (o_text.ready),
    .i_out_char  (o_text.char_code),
    .i_out_last  (o_text.last)
);

### tb/sv/fixed_to_decimal_text_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_to_decimal_text_core: directed numbers, then random ones.
// Each character word is checked against the typed text of its row or a local text predictor.
// Depends on ftd_pkg, ftd_if and the RTL of the converter.
module fixed_to_decimal_text_core_tb;
    import ftd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_PERCENT = 21;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ftd_in_if  num_if ();
    ftd_out_if text_if ();

    fixed_to_decimal_text_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_if),
        .o_text  (text_if)
    );

    t_text_char             expected_text[$];
    t_text_char             got_char;
    t_text_char             want_char;
    int                     mismatches  = 0;
    int                     cycle_count = 0;
    bit                     steady_run  = 1'b0;

    logic                   row_neg[$];
    logic [INT_BITS-1:0]    row_int[$];
    logic [FRAC_BITS-1:0]   row_frac[$];
    string                  row_text[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_text(input logic neg, input logic [INT_BITS-1:0] int_part,
                                         input logic [FRAC_BITS-1:0] frac);
        logic [CHAR_W-1:0]    chars[MAX_CHARS];
        logic [DIGIT_W-1:0]   rev_digits[INT_DIGITS];
        logic [INT_BITS-1:0]  rest;
        logic [FRAC_BITS-1:0] remain;
        logic [PROD_W-1:0]    prod;
        int                   n_rev;
        int                   len;
        int                   point_len;
        rest   = int_part;
        remain = frac;
        n_rev  = 0;
        len    = 0;
        do begin
            rev_digits[n_rev] = DIGIT_W'(rest % 10);
            rest  = INT_BITS'(rest / 10);
            n_rev = n_rev + 1;
        end while (rest != 0 && n_rev < INT_DIGITS);
        if (neg) begin
            chars[len] = CH_MINUS;
            len = len + 1;
        end
        for (int i = n_rev - 1; i >= 0; i--) begin
            chars[len] = CH_ZERO + CHAR_W'(rev_digits[i]);
            len = len + 1;
        end
        chars[len] = CH_POINT;
        len = len + 1;
        point_len = len;
        for (int i = 0; i < FRACTION_DIGITS && len < MAX_CHARS; i++) begin
            prod       = PROD_W'(remain) * PROD_W'(10);
            chars[len] = CH_ZERO + CHAR_W'(prod[PROD_W-1:FRAC_BITS]);
            remain     = prod[FRAC_BITS-1:0];
            len = len + 1;
        end
        while (len > point_len && chars[len-1] == CH_ZERO)
            len = len - 1;
        for (int i = 0; i < len; i++)
            expected_text.push_back('{code: chars[i], last: (i == len - 1)});
    endfunction

    function automatic void push_typed_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            expected_text.push_back('{code: CHAR_W'(txt[i]), last: (i == txt.len() - 1)});
    endfunction

    function automatic void add_row(input logic neg, input logic [INT_BITS-1:0] int_part,
                                    input logic [FRAC_BITS-1:0] frac, input string txt);
        row_neg.push_back(neg);
        row_int.push_back(int_part);
        row_frac.push_back(frac);
        row_text.push_back(txt);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_number(input logic neg, input logic [INT_BITS-1:0] int_part,
                               input logic [FRAC_BITS-1:0] frac, input string txt);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
            num_if.valid = 1'b0;
            @(negedge i_clk);
        end
        num_if.valid        = 1'b1;
        num_if.negative     = neg;
        num_if.integer_part = int_part;
        num_if.fraction     = frac;
        @(posedge i_clk);
        while (!num_if.ready)
            @(posedge i_clk);
        if (txt.len() != 0)
            push_typed_text(txt);
        else
            predict_text(neg, int_part, frac);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        text_if.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && text_if.valid && text_if.ready) begin
            got_char = '{code: text_if.char_code, last: text_if.last};
            if (expected_text.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected word: char %h last %b", got_char.code, got_char.last);
            end else begin
                want_char = expected_text.pop_front();
                if (got_char !== want_char) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Mismatch: expected char %h last %b, got char %h last %b",
                                 want_char.code, want_char.last, got_char.code, got_char.last);
                end
            end
        end
    end

    initial begin
        logic                 neg;
        logic [INT_BITS-1:0]  int_part;
        logic [FRAC_BITS-1:0] frac;
        longint               wide;
        int                   width;
        i_rst_n             = 1'b0;
        num_if.valid        = 1'b0;
        num_if.negative     = 1'b0;
        num_if.integer_part = '0;
        num_if.fraction     = '0;

        add_row(1'b0, 31'd0,          32'h0000_0000, "0.");
        add_row(1'b1, 31'd0,          32'h0000_0000, "-0.");
        add_row(1'b0, 31'd7,          32'h0000_0000, "7.");
        add_row(1'b0, 31'd9,          32'h0000_0000, "9.");
        add_row(1'b0, 31'd10,         32'h0000_0000, "10.");
        add_row(1'b0, 31'd1000000000, 32'h0000_0000, "1000000000.");
        add_row(1'b0, 31'h7FFF_FFFF,  32'h0000_0000, "2147483647.");
        add_row(1'b1, 31'h7FFF_FFFF,  32'hFFFF_FFFF, "-2147483647.9999");
        add_row(1'b0, 31'd0,          32'hFFFF_FFFF, "0.9999");
        add_row(1'b0, 31'd0,          32'h8000_0000, "0.5");
        add_row(1'b0, 31'd0,          32'h4000_0000, "0.25");
        add_row(1'b0, 31'd0,          32'h2000_0000, "0.125");
        add_row(1'b0, 31'd0,          32'h1000_0000, "0.0625");
        add_row(1'b1, 31'd0,          32'h0000_0001, "-0.");
        add_row(1'b0, 31'd0,          32'h0800_0000, "");
        add_row(1'b1, 31'd123,        32'h1999_999A, "");
        add_row(1'b0, 31'd0,          32'h0006_8DB9, "");
        add_row(1'b0, 31'd1,          32'h0001_A36E, "");
        add_row(1'b1, 31'h5555_5555,  32'hAAAA_AAAA, "");
        add_row(1'b0, 31'h2AAA_AAAA,  32'h5555_5555, "");
        add_row(1'b0, 31'h7FFF_FFFF,  32'h8000_0000, "");
        add_row(1'b1, 31'd999999999,  32'hE666_6666, "");

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < row_neg.size(); r++)
            send_number(row_neg[r], row_int[r], row_frac[r], row_text[r]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_run = (n >= 150 && n < 250);
            neg   = 1'(($urandom_range(0, 1)));
            width = $urandom_range(0, INT_BITS);
            if ($urandom_range(0, 9) == 0) begin
                wide     = 1;
                repeat ($urandom_range(0, 9)) wide = wide * 10;
                wide     = wide - $urandom_range(0, 1);
                int_part = ($urandom_range(0, 3) == 0) ? 31'h7FFF_FFFF : INT_BITS'(wide);
            end else begin
                int_part = INT_BITS'($urandom) & ((31'h1 << width) - 31'h1);
            end
            case ($urandom_range(0, 4))
                0: frac = '0;
                1: frac = $urandom & 32'hF000_0000;
                2: begin
                    wide = (longint'($urandom_range(0, 9999)) << FRAC_BITS) / 10000;
                    frac = FRAC_BITS'(wide + $urandom_range(0, 2));
                end
                default: frac = $urandom;
            endcase
            send_number(neg, int_part, frac, "");
        end
        steady_run   = 1'b0;
        num_if.valid = 1'b0;

        while (expected_text.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
